// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define IGEMM_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// The consequent must hold in the cycle of the antecedent.
`define IGEMM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IGEMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define IGEMM_ASSERT(lbl, clk, rstn, expr)
`define IGEMM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IGEMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/igemm_pkg.sv
`default_nettype none

package igemm_pkg;

  localparam int MaxDim    = 8;
  localparam int DimW      = $clog2(MaxDim);
  localparam int CntW      = $clog2(MaxDim + 1);
  localparam int DataW     = 32;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int AddrW     = $clog2(StoreDepth);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 4;

  // Command kinds.
  localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] KIND_RUN        = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DEPTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COL_COUNT   = 2'd2;

  localparam logic [CntW-1:0] DIM_RESET = CntW'(MaxDim);

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        row_index;
    logic [2:0]        col_index;
    logic signed [31:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [30:0] out_value;
    logic        last;
  } res_t;

  // One term travelling down the cell chain.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] a;
    logic [DimW-1:0]  d;
    logic             first;
    logic             last;
    logic             zero;
    logic [DimW-1:0]  row;
    logic             last_row;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_e;

  function automatic logic [CntW-1:0] clamp_dim(input logic [CntW-1:0] v);
    clamp_dim = (v > DIM_RESET) ? DIM_RESET : v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/igemm_ram.sv
`default_nettype none

module igemm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/igemm_cell.sv
`default_nettype none

module igemm_cell
  import igemm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [DimW-1:0]       idx_i,
  input  wire logic [CntW-1:0]       cols_i,
  input  wire logic                  wr_en_i,
  input  wire logic [DimW-1:0]       wr_row_i,
  input  wire logic [DimW-1:0]       wr_col_i,
  input  wire logic [DataW-1:0]      wr_data_i,
  input  wire tok_t                  tok_i,
  output      tok_t                  tok_o,
  output      logic                  res_valid_o,
  output      res_t                  res_o
);

  // This cell's column of the right matrix, one word per depth index.
  logic [DataW-1:0] col_q [MaxDim];
  tok_t             tok_q;
  tok_t             ptok_q;
  logic [DataW-1:0] prod_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] acc_d;
  logic             res_valid_q;
  logic [DimW-1:0]  res_row_q;
  logic             res_last_q;
  logic             in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_col_i == idx_i)) begin
      col_q[wr_row_i] <= wr_data_i;
    end
  end

  assign in_range = {1'b0, idx_i} < cols_i;

  always_comb begin
    acc_d = ptok_q.first ? prod_q : acc_q + prod_q;
  end

  // The term moves forward one stage per cycle; only its valid bit is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid  <= 1'b0;
      ptok_q.valid <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      tok_q        <= tok_i;
      ptok_q       <= tok_q;
      res_valid_q  <= ptok_q.valid && ptok_q.last && in_range;
    end
  end

  // Payload stages: multiply, then accumulate.
  always_ff @(posedge clk_i) begin
    prod_q          <= tok_q.zero ? '0 : DataW'(tok_q.a * col_q[tok_q.d]);

    if (ptok_q.valid) begin
      acc_q <= acc_d;
    end
    res_row_q  <= ptok_q.row;
    res_last_q <= ptok_q.last_row && ({1'b0, idx_i} == (cols_i - CntW'(1)));
  end

  assign tok_o       = tok_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o.out_row   = res_row_q;
    res_o.out_col   = idx_i;
    res_o.out_value = acc_q[DataW-1] ? '0 : acc_q[30:0];
    res_o.last      = res_last_q;
  end

endmodule

`default_nettype wire

// File: hw/rtl/igemm_seq.sv
`default_nettype none

module igemm_seq
  import igemm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              run_i,
  input  wire logic [CntW-1:0]   rows_i,
  input  wire logic [CntW-1:0]   dep_i,
  input  wire logic [CntW-1:0]   cols_i,
  input  wire logic              done_i,
  output      logic              busy_o,
  output      logic              rd_en_o,
  output      logic [AddrW-1:0]  rd_addr_o,
  output      tok_t              meta_o
);

  seq_state_e       state_q, state_d;
  logic [DimW-1:0]  row_q, row_d;
  logic [CntW-1:0]  step_q, step_d;
  logic [CntW-1:0]  dep_eff;
  logic [CntW-1:0]  period;
  logic             issue;
  tok_t             meta_d, meta_q;

  // Term metadata is registered so that it meets the registered left-store read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      step_q       <= '0;
      meta_q.valid <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      step_q       <= step_d;
      meta_q       <= meta_d;
    end
  end

  always_comb begin
    dep_eff = (dep_i == '0) ? CntW'(1) : dep_i;
    period  = (dep_eff > cols_i) ? dep_eff : cols_i;
    issue   = (state_q == ST_ISSUE) && (step_q < dep_eff);

    meta_d.valid    = issue;
    meta_d.a        = '0;
    meta_d.d        = step_q[DimW-1:0];
    meta_d.first    = (step_q == '0);
    meta_d.last     = (step_q == (dep_eff - CntW'(1)));
    meta_d.zero     = (dep_i == '0);
    meta_d.row      = row_q;
    meta_d.last_row = ({1'b0, row_q} == (rows_i - CntW'(1)));

    state_d = state_q;
    row_d   = row_q;
    step_d  = step_q;

    unique case (state_q)
      ST_IDLE: begin
        if (run_i) begin
          state_d = ST_ISSUE;
          row_d   = '0;
          step_d  = '0;
        end
      end
      ST_ISSUE: begin
        if (step_q == (period - CntW'(1))) begin
          step_d = '0;
          if (meta_d.last_row) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + DimW'(1);
          end
        end else begin
          step_d = step_q + CntW'(1);
        end
      end
      ST_DRAIN: begin
        if (done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign rd_en_o   = issue;
  assign rd_addr_o = {row_q, step_q[DimW-1:0]};
  assign meta_o    = meta_q;

endmodule

`default_nettype wire

// File: hw/rtl/integer_gemm_fused_relu.sv
`default_nettype none

// Integer matrix multiply with fused ReLU. Commands are transferred when start is high and
// busy is low. A left or right load writes one 32-bit element, so loads stream at one per
// clock while busy is low. A run computes every entry of the row_count by col_count product
// as a 32-bit wrapping dot product over inner_depth, clamps negative sums to zero and
// presents the entries in row-major order on res_valid_o, with last set on the final one.
// The entries of one row come on consecutive cycles, and rows are spaced so that one row's
// results leave the cell chain before the next row's begin. The receiver cannot stall:
// each result is valid for exactly one cycle and must be taken then. A run keeps busy high
// until its last result; busy falls in the cycle after the last result. A run with zero
// rows or zero columns produces nothing and does not raise busy. Configuration registers
// may be written only while busy is low; dimensions above eight act as eight.

module integer_gemm_fused_relu
  import igemm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire cmd_t                 cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output      logic                 res_valid_o,
  output      res_t                 res_o
);

  logic [CntW-1:0]  row_count_q;
  logic [CntW-1:0]  inner_depth_q;
  logic [CntW-1:0]  col_count_q;
  logic [CntW-1:0]  rows_eff;
  logic [CntW-1:0]  dep_eff;
  logic [CntW-1:0]  cols_eff;

  logic             accept;
  logic             run;
  logic             load_left;
  logic             load_right;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] rd_data;
  tok_t             meta;
  tok_t             chain [MaxDim];

  logic             cell_valid [MaxDim];
  res_t             cell_res   [MaxDim];
  logic [MaxDim-1:0] cell_valid_vec;

  logic             res_valid_q;
  res_t             res_q;
  logic             merged_valid;
  res_t             merged;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= DIM_RESET;
      inner_depth_q <= DIM_RESET;
      col_count_q   <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:   row_count_q   <= cfg_data_i;
        CFG_INNER_DEPTH: inner_depth_q <= cfg_data_i;
        CFG_COL_COUNT:   col_count_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign rows_eff = clamp_dim(row_count_q);
  assign dep_eff  = clamp_dim(inner_depth_q);
  assign cols_eff = clamp_dim(col_count_q);

  // Command decode. An unused kind is transferred and ignored.
  assign accept     = start && !busy;
  assign load_left  = accept && (cmd_i.kind == KIND_LOAD_LEFT);
  assign load_right = accept && (cmd_i.kind == KIND_LOAD_RIGHT);
  assign run        = accept && (cmd_i.kind == KIND_RUN)
                      && (rows_eff != '0) && (cols_eff != '0);

  // The sequencer walks rows and depth, reading one left element per cycle while it issues depth steps.
  igemm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_i     (run),
    .rows_i    (rows_eff),
    .dep_i     (dep_eff),
    .cols_i    (cols_eff),
    .done_i    (res_valid_q && res_q.last),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .meta_o    (meta)
  );

  // Left matrix store, addressed by row and depth index.
  igemm_ram #(
    .Width (DataW),
    .Depth (StoreDepth)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (load_left),
    .waddr_i ({cmd_i.row_index, cmd_i.col_index}),
    .wdata_i (cmd_i.element_value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // The term entering the chain carries the left element read this cycle.
  always_comb begin
    chain[0]   = meta;
    chain[0].a = rd_data;
  end

  // One cell per result column. Each holds its column of the right matrix, multiplies the
  // passing left element by the matching right element and accumulates. A term reaches
  // cell c in the cycle after it reaches cell c-1, so the finished sums of a row leave the cells
  // in column order on consecutive cycles and never collide.
  for (genvar c = 0; c < MaxDim; c++) begin : g_cell
    if (c < MaxDim - 1) begin : g_mid
      igemm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .idx_i       (DimW'(c)),
        .cols_i      (cols_eff),
        .wr_en_i     (load_right),
        .wr_row_i    (cmd_i.row_index),
        .wr_col_i    (cmd_i.col_index),
        .wr_data_i   (cmd_i.element_value),
        .tok_i       (chain[c]),
        .tok_o       (chain[c+1]),
        .res_valid_o (cell_valid[c]),
        .res_o       (cell_res[c])
      );
    end else begin : g_end
      igemm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .idx_i       (DimW'(c)),
        .cols_i      (cols_eff),
        .wr_en_i     (load_right),
        .wr_row_i    (cmd_i.row_index),
        .wr_col_i    (cmd_i.col_index),
        .wr_data_i   (cmd_i.element_value),
        .tok_i       (chain[c]),
        .tok_o       (),
        .res_valid_o (cell_valid[c]),
        .res_o       (cell_res[c])
      );
    end
    assign cell_valid_vec[c] = cell_valid[c];
  end

  // At most one cell finishes in any cycle, so the results are merged with an OR.
  always_comb begin
    merged_valid = 1'b0;
    merged       = '0;
    for (int c = 0; c < MaxDim; c++) begin
      if (cell_valid[c]) begin
        merged_valid = 1'b1;
        merged       = res_t'(merged | cell_res[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= merged_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= merged;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "assert_macros.svh"

  // Results only appear while a run is in progress.
  `IGEMM_ASSERT_SAME(a_res_in_run, clk_i, rst_ni, res_valid_o, busy)
  // A run with nonempty dimensions always raises busy.
  `IGEMM_ASSERT_NEXT(a_run_busy, clk_i, rst_ni, run, busy)
  // The last result of a run ends it.
  `IGEMM_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, res_valid_o && res_o.last, !busy)
  // Row spacing keeps the cells from finishing in the same cycle.
  `IGEMM_ASSERT(a_one_cell, clk_i, rst_ni, $onehot0(cell_valid_vec))

endmodule

`default_nettype wire
